### sv/apu_pkg.sv
package apu_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VM_W    = 48;   // second moment, Q16.32
  localparam int unsigned GSQ_W   = 48;   // g*g >> 16
  localparam int unsigned VH_W    = 62;   // bias-corrected second moment
  localparam int unsigned MAG_W   = 56;   // |m_hat| * step_size
  localparam int unsigned NUM_W   = 64;   // dividend, MAG << 8
  localparam int unsigned ROOT_W  = 48;
  localparam int unsigned DEN_W   = 49;
  localparam int unsigned QUO_W   = 35;
  localparam int unsigned CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    REG_FIRST_DECAY  = 3'd0,
    REG_SECOND_DECAY = 3'd1,
    REG_STEP_SIZE    = 3'd2,
    REG_STABILITY    = 3'd3,
    REG_FIRST_CORR   = 3'd4,
    REG_SECOND_CORR  = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
  localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
  localparam logic [23:0] STEP_SIZE_RST    = 24'd16777;
  localparam logic [31:0] STABILITY_RST    = 32'd43;
  localparam logic [31:0] FIRST_CORR_RST   = 32'd10485760;
  localparam logic [31:0] SECOND_CORR_RST  = 32'd1048576000;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

endpackage

### sv/apu_front.sv
module apu_front import apu_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         in_idx,
  input  logic signed [WORD_W-1:0] in_weight,
  input  logic signed [WORD_W-1:0] in_gradient,
  input  logic                     hold,
  input  logic                     pop,
  output logic                     iss_valid,
  output logic [AW-1:0]            iss_addr,
  output logic signed [WORD_W-1:0] iss_weight,
  output logic signed [WORD_W-1:0] iss_gradient,
  output logic [GSQ_W-1:0]         iss_gsq
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  // floor(2^32 / depth): quotient estimate is exact or one low
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(STORE_DEPTH));

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         q_est;
    logic signed [WORD_W-1:0] weight;
    logic signed [WORD_W-1:0] gradient;
  } qentry_t;

  qentry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    cnt, cnt_next;
  logic           push;
  logic [44:0]    prod;
  qentry_t        head;
  logic [32:0]    rem_raw, rem_fix;
  logic [WORD_W-1:0] gabs;

  assign in_ready = (cnt != (PW+1)'(QUEUE_DEPTH)) && !hold;
  assign push     = in_valid && in_ready;
  assign prod     = 45'(in_idx) * 45'(RECIP);

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 1'b1;
    else if (!push && pop) cnt_next = cnt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{idx: in_idx, q_est: prod[43:32],
                         weight: in_weight, gradient: in_gradient};
    end
  end

  // head of queue: address wrap and gradient square
  assign head      = slots[rd_ptr];
  assign iss_valid = (cnt != '0);
  assign rem_raw   = 33'(head.idx) - 33'(head.q_est) * 33'(STORE_DEPTH);
  assign rem_fix   = (rem_raw >= 33'(STORE_DEPTH)) ? rem_raw - 33'(STORE_DEPTH) : rem_raw;
  assign iss_addr  = rem_fix[AW-1:0];
  assign gabs      = head.gradient[WORD_W-1] ? WORD_W'(-head.gradient)
                                             : WORD_W'(head.gradient);
  assign iss_gsq   = GSQ_W'((64'(gabs) * 64'(gabs)) >> 16);
  assign iss_weight   = head.weight;
  assign iss_gradient = head.gradient;

endmodule

### sv/apu_moment.sv
module apu_moment import apu_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     take,
  input  logic [AW-1:0]            in_addr,
  input  logic signed [WORD_W-1:0] in_weight,
  input  logic signed [WORD_W-1:0] in_gradient,
  input  logic [GSQ_W-1:0]         in_gsq,
  input  logic [15:0]              first_decay,
  input  logic [15:0]              second_decay,
  output logic                     clearing,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_m,
  output logic [VM_W-1:0]          out_v,
  output logic signed [WORD_W-1:0] out_weight
);

  logic signed [WORD_W-1:0] mem_m [STORE_DEPTH];
  logic [VM_W-1:0]          mem_v [STORE_DEPTH];

  logic [AW-1:0]            clr_addr;
  logic                     a_valid;
  logic [AW-1:0]            a_addr;
  logic signed [WORD_W-1:0] a_w, a_g;
  logic [GSQ_W-1:0]         a_gsq;
  logic signed [WORD_W-1:0] rd_m, fwd_m, m_old, m_new;
  logic [VM_W-1:0]          rd_v, fwd_v, v_old, v_new;
  logic                     fwd;

  logic signed [16:0] b1s;
  logic signed [17:0] c1s;
  logic [16:0]        c2;
  logic signed [49:0] msum;
  logic [64:0]        vsum;

  // read-during-write of the same address: take the value being written
  assign m_old = fwd ? fwd_m : rd_m;
  assign v_old = fwd ? fwd_v : rd_v;

  assign b1s  = $signed({1'b0, first_decay});
  assign c1s  = $signed({1'b0, 17'h10000 - 17'(first_decay)});
  assign c2   = 17'h10000 - 17'(second_decay);
  assign msum = 50'(b1s) * 50'(m_old) + 50'(c1s) * 50'(a_g);
  assign vsum = 65'(second_decay) * 65'(v_old) + 65'(c2) * 65'(a_gsq);
  assign m_new = msum[47:16];
  assign v_new = vsum[63:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(STORE_DEPTH - 1)) clearing <= 1'b0;
      end
      if (en) begin
        a_valid   <= take;
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem_m[clr_addr] <= '0;
      mem_v[clr_addr] <= '0;
    end else if (en && a_valid) begin
      mem_m[a_addr] <= m_new;
      mem_v[a_addr] <= v_new;
    end
    if (en) begin
      rd_m <= mem_m[in_addr];
      rd_v <= mem_v[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_addr     <= in_addr;
      a_w        <= in_weight;
      a_g        <= in_gradient;
      a_gsq      <= in_gsq;
      fwd        <= a_valid && (a_addr == in_addr);
      fwd_m      <= m_new;
      fwd_v      <= v_new;
      out_m      <= m_new;
      out_v      <= v_new;
      out_weight <= a_w;
    end
  end

endmodule

### sv/apu_sqrt.sv
module apu_sqrt import apu_pkg::*; #(
  parameter int unsigned SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VH_W-1:0]   in_x,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  // floor(sqrt(x * 2^32)), one root bit per stage
  localparam int unsigned XW = 2 * ROOT_W;

  logic [49:0]       rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  logic [XW-1:0]     xs  [ROOT_W+1];
  logic [SB_W-1:0]   sb  [ROOT_W+1];
  logic              vld [ROOT_W+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign xs[0]  = {(XW-VH_W-32)'(0), in_x, 32'd0};
  assign sb[0]  = in_sb;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [51:0] cur, trial;
    logic        ge;
    assign cur   = {rem[s], xs[s][XW-1 -: 2]};
    assign trial = 52'({rt[s], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? 50'(cur - trial) : 50'(cur);
        rt[s+1]  <= {rt[s][ROOT_W-2:0], ge};
        xs[s+1]  <= {xs[s][XW-3:0], 2'b00};
        sb[s+1]  <= sb[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = rt[ROOT_W];
  assign out_sb    = sb[ROOT_W];

endmodule

### sv/apu_div.sv
module apu_div import apu_pkg::*; #(
  parameter int unsigned SB_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic             out_ovf,
  output logic [SB_W-1:0]  out_sb
);

  // restoring division, one quotient bit per stage; ovf marks q >= 2^QUO_W
  localparam int unsigned HW = NUM_W - QUO_W;

  logic [DEN_W-1:0] rem [QUO_W+1];
  logic [DEN_W-1:0] dn  [QUO_W+1];
  logic [QUO_W-1:0] nl  [QUO_W+1];
  logic [QUO_W-1:0] qo  [QUO_W+1];
  logic             ov  [QUO_W+1];
  logic [SB_W-1:0]  sb  [QUO_W+1];
  logic             vld [QUO_W+1];

  assign rem[0] = DEN_W'(in_num[NUM_W-1 -: HW]);
  assign dn[0]  = in_den;
  assign nl[0]  = in_num[QUO_W-1:0];
  assign qo[0]  = '0;
  assign ov[0]  = (DEN_W'(in_num[NUM_W-1 -: HW]) >= in_den);
  assign sb[0]  = in_sb;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [DEN_W:0] cur;
    logic           ge;
    assign cur = {rem[s], nl[s][QUO_W-1-s]};
    assign ge  = (cur >= {1'b0, dn[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? DEN_W'(cur - {1'b0, dn[s]}) : DEN_W'(cur);
        dn[s+1]  <= dn[s];
        nl[s+1]  <= nl[s];
        qo[s+1]  <= {qo[s][QUO_W-2:0], ge};
        ov[s+1]  <= ov[s];
        sb[s+1]  <= sb[s];
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_quo   = qo[QUO_W];
  assign out_ovf   = ov[QUO_W];
  assign out_sb    = sb[QUO_W];

endmodule

### sv/adam_parameter_update_unit.sv
// Channel   | Beat fields (low bit up)                          | Handshake
// s_axis    | element_index[11:0] weight[43:12] gradient[75:44] | tvalid/tready
// m_axis    | new_weight[31:0]                                  | tvalid/tready
// cfg       | cfg_index selects register, cfg_data value        | cfg_valid/cfg_ready
//
// One beat per cycle sustained while m_axis takes every beat and no store sweep runs.
// Pipeline depth is set mostly by the 48-stage square root and 35-stage divider pipelines.
// After rst the moment store is swept to zero, every address in turn, s_axis held off.
// A 4-beat queue decouples s_axis from the pipeline; the pipeline halts as a
// whole while m_axis holds a beat that is not taken.
module adam_parameter_update_unit import apu_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [79:0]       s_axis_tdata,   // element_index, weight, gradient, pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // new_weight
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned SQ_SB = WORD_W + 1 + MAG_W;
  localparam int unsigned DV_SB = WORD_W + 1;

  // configuration
  logic [15:0] first_decay, second_decay;
  logic [23:0] step_size;
  logic [31:0] stability_term, first_correction, second_correction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_decay       <= FIRST_DECAY_RST;
      second_decay      <= SECOND_DECAY_RST;
      step_size         <= STEP_SIZE_RST;
      stability_term    <= STABILITY_RST;
      first_correction  <= FIRST_CORR_RST;
      second_correction <= SECOND_CORR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRST_DECAY:  first_decay       <= cfg_data[15:0];
        REG_SECOND_DECAY: second_decay      <= cfg_data[15:0];
        REG_STEP_SIZE:    step_size         <= cfg_data[23:0];
        REG_STABILITY:    stability_term    <= cfg_data;
        REG_FIRST_CORR:   first_correction  <= cfg_data;
        REG_SECOND_CORR:  second_correction <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the whole back pipeline moves when the output slot frees
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;

  // front: queue and address wrap
  logic                     clearing;
  logic                     iss_valid, pop;
  logic [AW-1:0]            iss_addr;
  logic signed [WORD_W-1:0] iss_weight, iss_gradient;
  logic [GSQ_W-1:0]         iss_gsq;

  assign pop = en && iss_valid && !clearing;

  apu_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_idx       (s_axis_tdata[11:0]),
    .in_weight    (s_axis_tdata[43:12]),
    .in_gradient  (s_axis_tdata[75:44]),
    .hold         (clearing),
    .pop          (pop),
    .iss_valid    (iss_valid),
    .iss_addr     (iss_addr),
    .iss_weight   (iss_weight),
    .iss_gradient (iss_gradient),
    .iss_gsq      (iss_gsq)
  );

  // moment store read-modify-write
  logic                     mo_valid;
  logic signed [WORD_W-1:0] mo_m, mo_w;
  logic [VM_W-1:0]          mo_v;

  apu_moment #(.STORE_DEPTH(STORE_DEPTH)) u_moment (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .take         (pop),
    .in_addr      (iss_addr),
    .in_weight    (iss_weight),
    .in_gradient  (iss_gradient),
    .in_gsq       (iss_gsq),
    .first_decay  (first_decay),
    .second_decay (second_decay),
    .clearing     (clearing),
    .out_valid    (mo_valid),
    .out_m        (mo_m),
    .out_v        (mo_v),
    .out_weight   (mo_w)
  );

  // bias correction products
  logic                     c_valid;
  logic signed [64:0]       c_mprod;
  logic [55:0]              c_vhi, c_vlo;
  logic signed [WORD_W-1:0] c_w;

  // m_hat saturation and v_hat sum
  logic                     d_valid;
  logic signed [WORD_W-1:0] d_mh, d_w;
  logic [VH_W-1:0]          d_vh;
  logic signed [64:0]       msh;
  logic                     pos_ovf, neg_ovf;

  // step-scaled magnitude
  logic                     e_valid;
  logic [MAG_W-1:0]         e_mag;
  logic                     e_neg;
  logic [VH_W-1:0]          e_vh;
  logic signed [WORD_W-1:0] e_w;
  logic [WORD_W-1:0]        mabs;

  assign msh     = c_mprod >>> 20;
  assign pos_ovf = !msh[64] && (|msh[63:31]);
  assign neg_ovf =  msh[64] && !(&msh[63:31]);
  assign mabs    = d_mh[WORD_W-1] ? WORD_W'(-d_mh) : WORD_W'(d_mh);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      c_valid <= mo_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mprod <= 65'(mo_m) * $signed(65'(first_correction));
      c_vhi   <= 56'(mo_v[47:24]) * 56'(second_correction);
      c_vlo   <= 56'(mo_v[23:0]) * 56'(second_correction);
      c_w     <= mo_w;

      if (pos_ovf)      d_mh <= WORD_MAX;
      else if (neg_ovf) d_mh <= WORD_MIN;
      else              d_mh <= msh[WORD_W-1:0];
      d_vh <= VH_W'({c_vhi, 4'b0000}) + VH_W'(c_vlo[55:20]);
      d_w  <= c_w;

      e_mag <= MAG_W'(mabs) * MAG_W'(step_size);
      e_neg <= d_mh[WORD_W-1];
      e_vh  <= d_vh;
      e_w   <= d_w;
    end
  end

  // square root of v_hat
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SQ_SB-1:0]  sq_sb;

  apu_sqrt #(.SB_W(SQ_SB)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_x      (e_vh),
    .in_sb     ({e_w, e_neg, e_mag}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // denominator, zero taken as one LSB
  logic             f_valid;
  logic [DEN_W-1:0] f_den, den_sum;
  logic [NUM_W-1:0] f_num;
  logic [DV_SB-1:0] f_sb;

  assign den_sum = DEN_W'(sq_root) + DEN_W'(stability_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_den <= (den_sum == '0) ? DEN_W'(1) : den_sum;
      f_num <= {sq_sb[MAG_W-1:0], 8'd0};
      f_sb  <= sq_sb[SQ_SB-1:MAG_W];
    end
  end

  // quotient
  logic             dv_valid, dv_ovf;
  logic [QUO_W-1:0] dv_quo;
  logic [DV_SB-1:0] dv_sb;

  apu_div #(.SB_W(DV_SB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_sb     (f_sb),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf),
    .out_sb    (dv_sb)
  );

  // final step, saturate to Q8.24
  logic signed [WORD_W-1:0] fin_w, new_weight;
  logic                     fin_neg;
  logic signed [36:0]       fin_q, nw_wide;

  assign fin_w   = dv_sb[DV_SB-1:1];
  assign fin_neg = dv_sb[0];
  assign fin_q   = $signed(37'(dv_quo));
  assign nw_wide = fin_neg ? 37'(fin_w) + fin_q : 37'(fin_w) - fin_q;

  always_comb begin
    if (dv_ovf)                   new_weight = fin_neg ? WORD_MAX : WORD_MIN;
    else if (nw_wide > 37'(WORD_MAX)) new_weight = WORD_MAX;
    else if (nw_wide < 37'(WORD_MIN)) new_weight = WORD_MIN;
    else                          new_weight = nw_wide[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= new_weight;
  end

`ifndef NO_ASSERTIONS
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> clearing)
    else $error("store sweep not running after reset");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_axis_tvalid)
    else $error("result beat during store sweep");

  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !mo_valid && !pop)
    else $error("moment update during store sweep");
`endif

endmodule

### bench/adam_checker.sv
module adam_checker import apu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);

  logic [15:0] beta1, beta2;
  logic [23:0] lrate;
  logic [31:0] eps, corr1, corr2;
  logic signed [31:0] mom1 [STORE_DEPTH_DEF];
  logic [47:0] mom2 [STORE_DEPTH_DEF];
  logic signed [31:0] weight_q [$];

  assign pending = weight_q.size();

  function automatic logic signed [31:0] adam_update(logic [11:0] idx,
                                                     logic signed [31:0] w,
                                                     logic signed [31:0] g);
    longint m, mh, nw;
    logic [127:0] ga, g2, v, vh, tgt, c, r, den, mag, q;
    ga = (g < 0) ? -longint'(g) : longint'(g);
    g2 = (ga * ga) >> 16;
    m = (longint'(beta1) * longint'(mom1[idx]) + (65536 - longint'(beta1)) * longint'(g))
        >>> 16;
    mom1[idx] = m[31:0];
    v = ((128'(beta2) * mom2[idx] + (128'd65536 - beta2) * g2) >> 16) & 128'hFFFF_FFFF_FFFF;
    mom2[idx] = v[47:0];
    mh = (m * longint'({1'b0, corr1})) >>> 20;
    if (mh > 64'sd2147483647) mh = 64'sd2147483647;
    if (mh < -64'sd2147483648) mh = -64'sd2147483648;
    vh = (((v >> 24) * corr2) << 4) + (((v & 128'hFF_FFFF) * corr2) >> 20);
    vh = vh & 128'hFFFF_FFFF_FFFF_FFFF;
    tgt = vh << 32;
    r = 0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= tgt) r = c;
    end
    den = r + eps;
    if (den == 0) den = 1;
    mag = (128'((mh < 0) ? -mh : mh) * lrate) << 8;
    q = mag / den;
    if (q > (128'd1 << 34)) q = 128'd1 << 34;
    nw = (mh < 0) ? longint'(w) + longint'(q) : longint'(w) - longint'(q);
    if (nw > 64'sd2147483647) nw = 64'sd2147483647;
    if (nw < -64'sd2147483648) nw = -64'sd2147483648;
    return nw[31:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (rst) begin
      beta1 <= FIRST_DECAY_RST;
      beta2 <= SECOND_DECAY_RST;
      lrate <= STEP_SIZE_RST;
      eps   <= STABILITY_RST;
      corr1 <= FIRST_CORR_RST;
      corr2 <= SECOND_CORR_RST;
      for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
        mom1[i] = '0;
        mom2[i] = '0;
      end
      weight_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIRST_DECAY:  beta1 <= cfg_data[15:0];
          REG_SECOND_DECAY: beta2 <= cfg_data[15:0];
          REG_STEP_SIZE:    lrate <= cfg_data[23:0];
          REG_STABILITY:    eps   <= cfg_data;
          REG_FIRST_CORR:   corr1 <= cfg_data;
          REG_SECOND_CORR:  corr2 <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (weight_q.size() == 0)
          report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
        else if (m_axis_tdata !== weight_q[0]) begin
          report_mismatch($sformatf("new_weight %h, want %h", m_axis_tdata, weight_q[0]));
          void'(weight_q.pop_front());
        end else
          void'(weight_q.pop_front());
      end
      if (s_axis_tvalid && s_axis_tready)
        weight_q.push_back(adam_update(s_axis_tdata[11:0], s_axis_tdata[43:12],
                                       s_axis_tdata[75:44]));
    end
  end

endmodule

### bench/tb.sv
module tb;
  import apu_pkg::*;

  localparam int DRAIN_CYCLES = 120;     // a bit beyond the pipeline depth
  localparam int STALL_LIMIT  = 20000;   // covers the post-reset store sweep

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // element_index[11:0] weight[43:12] gradient[75:44]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // new_weight[31:0]
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int fails, pending;
  int tx_idle_pct = 6;   // sender idle chance per cycle, percent
  int rx_idle_pct = 53;  // receiver stall chance per cycle, percent
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  adam_parameter_update_unit dut (.*);

  adam_checker chk (.*);

  // receiver: random backpressure
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // watchdog: cycles with no beat anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= r;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // one element beat; gaps only when the sender idles, so valid stays up back to back
  task automatic send_element(logic [11:0] idx, logic [31:0] w, logic [31:0] g);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {4'h0, g, w, idx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] b1, logic [15:0] b2, logic [23:0] lr,
                           logic [31:0] ep, logic [31:0] c1, logic [31:0] c2);
    write_reg(REG_FIRST_DECAY, b1);
    write_reg(REG_SECOND_DECAY, b2);
    write_reg(REG_STEP_SIZE, lr);
    write_reg(REG_STABILITY, ep);
    write_reg(REG_FIRST_CORR, c1);
    write_reg(REG_SECOND_CORR, c2);
  endtask

  function automatic logic [31:0] rand_grad();
    logic [31:0] x;
    x = $urandom();
    // spread magnitudes: most small, some full scale
    return (x[31]) ? ~(x >> $urandom_range(31)) : (x >> $urandom_range(31));
  endfunction

  // random item set; mostly a small element pool so moments build up
  task automatic random_items(int n);
    logic [11:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(9) < 8) ? 12'($urandom_range(31)) : 12'($urandom());
      send_element(idx, $urandom(), rand_grad());
      if (i == n / 2 && $urandom_range(1)) drain();   // sender waits for all results
    end
  endtask

  task automatic random_config;
    case ($urandom_range(3))
      0: write_all(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      1: write_all(16'h0, 16'h0, 24'h0, 32'h0, 32'h0, 32'h0);
      default: write_all(16'($urandom_range(50000, 65535)), 16'($urandom_range(60000, 65535)),
                         24'($urandom_range(1, 300000)), $urandom_range(200),
                         $urandom_range(1 << 20, 1 << 24), $urandom_range(1 << 20, 1 << 30));
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: first touch on reset registers, field extremes
    send_element(12'h000, 32'h0000_0000, 32'h0000_0000);
    send_element(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_element(12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_element(12'h001, 32'h8000_0000, 32'h8000_0000);
    send_element(12'h001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_element(12'hAAA, 32'hAAAA_AAAA, 32'h5555_5555);
    send_element(12'h555, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    // zero decay, zero epsilon: moments are the sample; tiny gradient gives zero denominator
    write_all(16'h0, 16'h0, 24'hFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0010_0000);
    send_element(12'h010, 32'h0100_0000, 32'h0000_0001);
    send_element(12'h011, 32'h7FFF_FFF0, 32'hFFFF_FFFF);
    send_element(12'h012, 32'h0000_0000, 32'h0000_0000);
    send_element(12'h013, 32'h8000_0000, 32'h0000_0100);
    drain();

    // all registers at top
    write_all(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_element(12'h020, 32'h0000_0000, 32'h7FFF_FFFF);
    send_element(12'h020, 32'h0000_0000, 32'h8000_0000);
    send_element(12'h021, 32'h1234_5678, 32'h0123_4567);
    drain();

    // three idling regimes, several settings each
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 53 : 0;
      rx_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        random_config();
        random_items(102);
        drain();
      end
    end

    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
sv/apu_pkg.sv
sv/apu_front.sv
sv/apu_moment.sv
sv/apu_sqrt.sv
sv/apu_div.sv
sv/adam_parameter_update_unit.sv
bench/adam_checker.sv
bench/tb.sv
